FILE: hdl/gsrc_pkg.sv
// ----------------------------------------------------------------------------
// gsrc_pkg
// Shared types and constants of the gated setpoint ramp with clamp.
// ----------------------------------------------------------------------------
package gsrc_pkg;

	localparam int JOINTS_DEF    = 10;
	localparam int POS_WIDTH_DEF = 16;
	localparam int CFG_W         = 16;
	localparam int CFG_IDX_W     = 4;
	localparam int JNT_W         = 4;
	localparam int REQ_W         = 3;

	// Q16 fixed-point one and the 3.0 factor of the smoothstep polynomial.
	localparam logic [16:0] ONE_Q16  = 17'd65536;
	localparam logic [17:0] THREE_Q16 = 18'd196608;

	localparam logic [CFG_W-1:0] RAMP_TICKS_RST    = 16'd150;
	localparam logic [CFG_W-1:0] TIMEOUT_TICKS_RST = 16'd25;

	typedef enum logic [REQ_W-1:0] {
		REQ_TICK     = 3'd0,
		REQ_MEASURED = 3'd1,
		REQ_TARGET   = 3'd2,
		REQ_GATE     = 3'd3,
		REQ_LOAD     = 3'd4
	} req_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RAMP_TICKS    = 4'd0,
		REG_TIMEOUT_TICKS = 4'd1
	} cfg_reg_t;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_DIV  = 6'b000010,
		ST_SQ   = 6'b000100,
		ST_CUBE = 6'b001000,
		ST_JMUL = 6'b010000,
		ST_JOUT = 6'b100000
	} state_t;

	typedef struct packed {
		logic item_en;
		logic div_start;
		logic s_full;
		logic sq_en;
		logic cube_en;
		logic jmul_en;
		logic jout_en;
		logic tick_end;
	} cmd_t;

	typedef struct packed {
		logic gate_on;
		logic need_div;
		logic div_done;
		logic last_jnt;
		logic out_free;
	} stat_t;

endpackage

FILE: hdl/gsrc_div.sv
// ----------------------------------------------------------------------------
// gsrc_div
// Restoring divider for the ramp fraction, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gsrc_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] elapsed,
	input  logic [15:0] divisor,
	output logic        done,
	output logic [15:0] quo
);

	logic [16:0] rem_q;
	logic [15:0] quo_q;
	logic [3:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [16:0] shifted;
	logic        fits;

	// The dividend is elapsed * 2^16 with elapsed below the divisor, so the
	// upper quotient half is zero and the remainder starts at elapsed.
	assign shifted = {rem_q[15:0], 1'b0};
	assign fits    = shifted >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, elapsed};
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? (shifted - {1'b0, divisor}) : shifted;
			quo_q <= {quo_q[14:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

FILE: hdl/gsrc_datapath.sv
// ----------------------------------------------------------------------------
// gsrc_datapath
// Joint tables, counters, smoothstep unit, per-joint blend, clamp and output.
// ----------------------------------------------------------------------------
module gsrc_datapath #(
	parameter int JOINTS    = gsrc_pkg::JOINTS_DEF,
	parameter int POS_WIDTH = gsrc_pkg::POS_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  gsrc_pkg::cmd_t               cmd,
	output gsrc_pkg::stat_t              stat,
	input  logic [gsrc_pkg::REQ_W-1:0]   req_type,
	input  logic [gsrc_pkg::JNT_W-1:0]   joint,
	input  logic [POS_WIDTH-1:0]         position,
	input  logic                         gate_enabled,
	input  logic [POS_WIDTH-1:0]         home_pos,
	input  logic [POS_WIDTH-1:0]         min_pos,
	input  logic [POS_WIDTH-1:0]         max_pos,
	input  logic                         cfg_we,
	input  logic [gsrc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gsrc_pkg::CFG_W-1:0]   cfg_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [gsrc_pkg::JNT_W-1:0]   out_joint,
	output logic [POS_WIDTH-1:0]         q_des,
	output logic                         last_joint
);

	localparam int JIDX_W = (JOINTS > 1) ? $clog2(JOINTS) : 1;
	localparam int PW     = POS_WIDTH;
	localparam int PROD_W = PW + 19;
	localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) << 15;
	localparam int JNT_W_L = gsrc_pkg::JNT_W;

	logic [PW-1:0] meas_q   [JOINTS];
	logic [PW-1:0] tgt_q    [JOINTS];
	logic [PW-1:0] origin_q [JOINTS];
	logic [PW-1:0] home_q   [JOINTS];
	logic [PW-1:0] min_q    [JOINTS];
	logic [PW-1:0] max_q    [JOINTS];
	logic          meas_valid_q;
	logic          tgt_seen_q;
	logic [15:0]   tgt_age_q;
	logic          gate_q;
	logic          ramp_q;
	logic [15:0]   elapsed_q;
	logic [15:0]   ramp_ticks_q;
	logic [15:0]   timeout_q;
	logic          fresh_q;
	logic [JIDX_W-1:0] jidx_q;
	logic [31:0]   sq_q;
	logic [16:0]   s_q;

	logic signed [PROD_W-1:0] prod_s1;
	logic signed [PW-1:0]     org_s1;
	logic signed [PW-1:0]     min_s1;
	logic signed [PW-1:0]     max_s1;

	logic                out_valid_q;
	logic [JNT_W_L-1:0]  out_joint_q;
	logic [PW-1:0]       out_q_q;
	logic                out_last_q;

	logic [15:0]   r_eff;
	logic          jnt_ok;
	logic [JIDX_W-1:0] jsel;
	logic          div_done;
	logic [15:0]   div_quo;
	logic [17:0]   poly_w;
	logic [50:0]   cube_sum;
	logic signed [PW-1:0] d_cur;
	logic signed [PW-1:0] o_cur;
	logic signed [PW:0]   diff;
	logic signed [PROD_W-1:0] rnd;
	logic signed [PW+2:0] q_full;
	logic signed [PW+2:0] q_clamp;
	logic          out_free;

	assign r_eff  = (ramp_ticks_q == 16'd0) ? 16'd1 : ramp_ticks_q;
	assign jnt_ok = {1'b0, joint} < 5'(JOINTS);
	assign jsel   = joint[JIDX_W-1:0];

	gsrc_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.elapsed (elapsed_q),
		.divisor (r_eff),
		.done    (div_done),
		.quo     (div_quo)
	);

	// Control and table state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < JOINTS; i++) begin
				meas_q[i]   <= '0;
				tgt_q[i]    <= '0;
				origin_q[i] <= '0;
				home_q[i]   <= '0;
				min_q[i]    <= '0;
				max_q[i]    <= '0;
			end
			meas_valid_q <= 1'b0;
			tgt_seen_q   <= 1'b0;
			tgt_age_q    <= '0;
			gate_q       <= 1'b0;
			ramp_q       <= 1'b0;
			elapsed_q    <= '0;
			ramp_ticks_q <= gsrc_pkg::RAMP_TICKS_RST;
			timeout_q    <= gsrc_pkg::TIMEOUT_TICKS_RST;
			fresh_q      <= 1'b0;
			jidx_q       <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					gsrc_pkg::REG_RAMP_TICKS:    ramp_ticks_q <= cfg_data;
					gsrc_pkg::REG_TIMEOUT_TICKS: timeout_q    <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.item_en) begin
				jidx_q  <= '0;
				fresh_q <= tgt_seen_q && (tgt_age_q <= timeout_q);
				unique case (req_type)
					gsrc_pkg::REQ_MEASURED: begin
						if (jnt_ok) begin
							meas_q[jsel] <= position;
							meas_valid_q <= 1'b1;
						end
					end
					gsrc_pkg::REQ_TARGET: begin
						if (jnt_ok) begin
							tgt_q[jsel] <= position;
							tgt_seen_q  <= 1'b1;
							tgt_age_q   <= '0;
						end
					end
					gsrc_pkg::REQ_GATE: begin
						if (gate_enabled && !gate_q) begin
							for (int i = 0; i < JOINTS; i++)
								origin_q[i] <= meas_valid_q ? meas_q[i] : home_q[i];
							elapsed_q <= '0;
							ramp_q    <= 1'b1;
						end
						gate_q <= gate_enabled;
					end
					gsrc_pkg::REQ_LOAD: begin
						if (jnt_ok) begin
							home_q[jsel] <= home_pos;
							min_q[jsel]  <= min_pos;
							max_q[jsel]  <= max_pos;
						end
					end
					default: ;
				endcase
			end
			if (cmd.jout_en)
				jidx_q <= jidx_q + JIDX_W'(1);
			if (cmd.tick_end) begin
				if (gate_q && ramp_q && (elapsed_q >= r_eff))
					ramp_q <= 1'b0;
				if (tgt_age_q != 16'hFFFF)
					tgt_age_q <= tgt_age_q + 16'd1;
				if (elapsed_q != 16'hFFFF)
					elapsed_q <= elapsed_q + 16'd1;
			end
		end
	end

	// Smoothstep: s = round(a*a*(3 - 2a)) in Q16.
	assign poly_w   = gsrc_pkg::THREE_Q16 - {1'b0, div_quo, 1'b0};
	assign cube_sum = 51'(sq_q) * 51'(poly_w) + (51'(1) << 31);

	always_ff @(posedge clk) begin
		if (cmd.sq_en)
			sq_q <= 32'(div_quo) * 32'(div_quo);
		if (cmd.s_full)
			s_q <= gsrc_pkg::ONE_Q16;
		else if (cmd.cube_en)
			s_q <= cube_sum[48:32];
	end

	// Per-joint blend, first stage: difference and product.
	assign d_cur = fresh_q ? $signed(tgt_q[jidx_q]) : $signed(home_q[jidx_q]);
	assign o_cur = $signed(origin_q[jidx_q]);
	assign diff  = {d_cur[PW-1], d_cur} - {o_cur[PW-1], o_cur};

	always_ff @(posedge clk) begin
		if (cmd.jmul_en) begin
			prod_s1 <= PROD_W'($signed({1'b0, s_q})) * PROD_W'(diff);
			org_s1  <= o_cur;
			min_s1  <= $signed(min_q[jidx_q]);
			max_s1  <= $signed(max_q[jidx_q]);
		end
	end

	// Second stage: rounding, origin add and clamp.
	assign rnd    = (prod_s1 + RND_HALF) >>> 16;
	assign q_full = (PW+3)'(org_s1) + rnd[PW+2:0];

	always_comb begin
		q_clamp = q_full;
		if (q_full < (PW+3)'(min_s1))
			q_clamp = (PW+3)'(min_s1);
		else if (q_full > (PW+3)'(max_s1))
			q_clamp = (PW+3)'(max_s1);
	end

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.jout_en)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.jout_en) begin
			out_joint_q <= JNT_W_L'(jidx_q);
			out_q_q     <= q_clamp[PW-1:0];
			out_last_q  <= (jidx_q == JIDX_W'(JOINTS - 1));
		end
	end

	assign stat.gate_on  = gate_q;
	assign stat.need_div = ramp_q && (elapsed_q < r_eff);
	assign stat.div_done = div_done;
	assign stat.last_jnt = (jidx_q == JIDX_W'(JOINTS - 1));
	assign stat.out_free = out_free;

	assign out_valid  = out_valid_q;
	assign out_joint  = out_joint_q;
	assign q_des      = out_q_q;
	assign last_joint = out_last_q;

endmodule

FILE: hdl/gsrc_ctrl.sv
// ----------------------------------------------------------------------------
// gsrc_ctrl
// Sequencer for one item: accept, smoothstep setup, then the joint walk.
// ----------------------------------------------------------------------------
module gsrc_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [gsrc_pkg::REQ_W-1:0] req_type,
	input  gsrc_pkg::stat_t            stat,
	output gsrc_pkg::cmd_t             cmd
);

	gsrc_pkg::state_t state_q;
	gsrc_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= gsrc_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			gsrc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.item_en = 1'b1;
					if (req_type == gsrc_pkg::REQ_TICK) begin
						if (!stat.gate_on) begin
							cmd.tick_end = 1'b1;
						end else if (stat.need_div) begin
							cmd.div_start = 1'b1;
							state_d = gsrc_pkg::ST_DIV;
						end else begin
							// Outside a ramp the blend weight is exactly one.
							cmd.s_full = 1'b1;
							state_d = gsrc_pkg::ST_JMUL;
						end
					end
				end
			end
			gsrc_pkg::ST_DIV: begin
				if (stat.div_done)
					state_d = gsrc_pkg::ST_SQ;
			end
			gsrc_pkg::ST_SQ: begin
				cmd.sq_en = 1'b1;
				state_d = gsrc_pkg::ST_CUBE;
			end
			gsrc_pkg::ST_CUBE: begin
				cmd.cube_en = 1'b1;
				state_d = gsrc_pkg::ST_JMUL;
			end
			gsrc_pkg::ST_JMUL: begin
				cmd.jmul_en = 1'b1;
				state_d = gsrc_pkg::ST_JOUT;
			end
			gsrc_pkg::ST_JOUT: begin
				if (stat.out_free) begin
					cmd.jout_en = 1'b1;
					if (stat.last_jnt) begin
						cmd.tick_end = 1'b1;
						state_d = gsrc_pkg::ST_IDLE;
					end else begin
						state_d = gsrc_pkg::ST_JMUL;
					end
				end
			end
			default: state_d = gsrc_pkg::ST_IDLE;
		endcase
	end

endmodule

FILE: hdl/gated_setpoint_ramp_clamp_top.sv
// ----------------------------------------------------------------------------
// gated_setpoint_ramp_clamp_top
// Per-joint setpoint generator with gated smoothstep ramp and position clamp.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Content
// s_*       in         s_tvalid/s_tready    request item, kind in s_tuser
// m_*       out        m_tvalid/m_tready    one joint command, tlast on last joint
// cfg_*     in         cfg_valid/cfg_ready  register write, index and data
//
// Update, load and gate items, and a tick with the gate off, never leave idle.
// An enabled tick walks every joint through the JMUL and JOUT states, and
// while ramping first runs the 16-step ramp fraction divider and the two
// smoothstep multiplies. Reset clears the tables, flags and counters.
// A stalled output holds the joint walk; the config port is always ready.
// ----------------------------------------------------------------------------
module gated_setpoint_ramp_clamp_top #(
	parameter int JOINTS    = gsrc_pkg::JOINTS_DEF,
	parameter int POS_WIDTH = gsrc_pkg::POS_WIDTH_DEF,
	localparam int IN_W     = ((gsrc_pkg::JNT_W + 4 * POS_WIDTH + 1 + 7) / 8) * 8,
	localparam int OUT_W    = ((gsrc_pkg::JNT_W + POS_WIDTH + 7) / 8) * 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// joint, position, gate_enabled, home_pos, min_pos, max_pos
	input  logic [IN_W-1:0]                s_tdata,
	// req_type
	input  logic [gsrc_pkg::REQ_W-1:0]     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// out_joint, q_des
	output logic [OUT_W-1:0]               m_tdata,
	output logic                           m_tlast,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [gsrc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gsrc_pkg::CFG_W-1:0]     cfg_data
);

	localparam int PW = POS_WIDTH;
	localparam int JW = gsrc_pkg::JNT_W;

	gsrc_pkg::cmd_t  cmd;
	gsrc_pkg::stat_t stat;
	logic [JW-1:0]   out_joint;
	logic [PW-1:0]   q_des;

	assign cfg_ready = 1'b1;

	gsrc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.req_type (s_tuser),
		.stat     (stat),
		.cmd      (cmd)
	);

	gsrc_datapath #(
		.JOINTS    (JOINTS),
		.POS_WIDTH (POS_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.req_type     (s_tuser),
		.joint        (s_tdata[JW-1:0]),
		.position     (s_tdata[JW+PW-1:JW]),
		.gate_enabled (s_tdata[JW+PW]),
		.home_pos     (s_tdata[JW+2*PW:JW+PW+1]),
		.min_pos      (s_tdata[JW+3*PW:JW+2*PW+1]),
		.max_pos      (s_tdata[JW+4*PW:JW+3*PW+1]),
		.cfg_we       (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_joint    (out_joint),
		.q_des        (q_des),
		.last_joint   (m_tlast)
	);

	assign m_tdata = OUT_W'({q_des, out_joint});

`ifndef SYNTH
	a_last_is_final_joint: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[JW-1:0] == JW'(JOINTS - 1))
		else $error("tlast on a joint other than the final one");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.jout_en |-> (!m_tvalid || m_tready))
		else $error("joint command loaded over a pending result");

	a_div_busy_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_done |-> !s_tready)
		else $error("divider finished while input was open");
`endif

endmodule
